### rtl/sis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

    // Fixed port widths
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_PUT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/sis_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/sorted_interval_set_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a scan up to the ordered position p, a decide step, then an insert shifts
// (count - p) entries up and writes the new pair, a remove shifts (count - p - 1) entries
// down, and the done state loads the result once the output register is free.
// One operation at a time: o_stall stays high until the sequencer is back in idle.
// Reset (synchronous, active low) empties the set and clears the result valid flag.

module sorted_interval_set_unit #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Command channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_cmd,
    input  wire logic [sis_pkg::TIME_W-1:0]    i_start_time,
    input  wire logic [sis_pkg::TIME_W-1:0]    i_end_time,
    // Result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [sis_pkg::STATUS_W-1:0]  o_status,
    output logic      [sis_pkg::POS_W-1:0]     o_position,
    output logic      [sis_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                               o_is_empty
);

    import sis_pkg::*;

    localparam int KW     = (KEY_BITS < TIME_W) ? KEY_BITS : TIME_W;
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = 2 * KW;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_p, n_p;
    logic              r_match, n_match;
    logic              r_cmd, n_cmd;
    logic [KW-1:0]     r_key_s, n_key_s;
    logic [KW-1:0]     r_key_e, n_key_e;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [CNT_W-1:0]  r_out_pos, n_out_pos;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [KW-1:0]     ent_s, ent_e;
    logic              ent_less, ent_equal;
    logic [CNT_W-1:0]  idx_inc, idx_inc2, idx_dec, idx_dec2, cnt_dec, cnt_inc, p_inc;
    logic              out_free;

    // Pair storage, one word of {start, end} per slot
    sis_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared comparator against the slot being read
    assign ent_s     = ram_rdata[WORD_W-1:KW];
    assign ent_e     = ram_rdata[KW-1:0];
    assign ent_less  = (ent_s < r_key_s) || ((ent_s == r_key_s) && (ent_e < r_key_e));
    assign ent_equal = (ent_s == r_key_s) && (ent_e == r_key_e);

    // Index arithmetic
    assign idx_inc  = r_idx + CNT_W'(1);
    assign idx_inc2 = r_idx + CNT_W'(2);
    assign idx_dec  = r_idx - CNT_W'(1);
    assign idx_dec2 = r_idx - CNT_W'(2);
    assign cnt_dec  = r_cnt - CNT_W'(1);
    assign cnt_inc  = r_cnt + CNT_W'(1);
    assign p_inc    = r_p + CNT_W'(1);

    assign out_free = !r_out_valid || !i_stall;

    // Hold state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_p          <= n_p;
        r_match      <= n_match;
        r_cmd        <= n_cmd;
        r_key_s      <= n_key_s;
        r_key_e      <= n_key_e;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_cnt    <= n_out_cnt;
    end

    // Sequencer: scan, decide, shift, write, deliver
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_p          = r_p;
        n_match      = r_match;
        n_cmd        = r_cmd;
        n_key_s      = r_key_s;
        n_key_e      = r_key_e;
        n_cnt        = r_cnt;
        n_status     = r_status;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_cnt    = r_out_cnt;
        ram_we       = 1'b0;
        ram_waddr    = IDX_W'(r_idx);
        ram_wdata    = ram_rdata;
        ram_raddr    = '0;

        // Drop the result once the consumer takes it
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // Prefetch slot zero for the scan
                ram_raddr = '0;
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_key_s = i_start_time[KW-1:0];
                    n_key_e = i_end_time[KW-1:0];
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Advance while the stored pair orders before the key
                ram_raddr = IDX_W'(idx_inc);
                if (r_idx == r_cnt) begin
                    n_p     = r_idx;
                    n_match = 1'b0;
                    n_state = ST_DECIDE;
                end else if (ent_less) begin
                    n_idx = idx_inc;
                end else begin
                    n_p     = r_idx;
                    n_match = ent_equal;
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_match) begin
                        n_status = STAT_DUP;
                        n_pos    = r_p;
                        n_state  = ST_DONE;
                    end else if (r_cnt == CNT_W'(CAPACITY)) begin
                        n_status = STAT_FULL;
                        n_pos    = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_status = STAT_DONE;
                        n_pos    = r_p;
                        n_cnt    = cnt_inc;
                        if (r_p < r_cnt) begin
                            // Move the tail up, starting at the old last slot
                            ram_raddr = IDX_W'(cnt_dec);
                            n_idx     = r_cnt;
                            n_state   = ST_SHIFT_UP;
                        end else begin
                            n_state = ST_PUT;
                        end
                    end
                end else begin
                    if (r_match) begin
                        n_status = STAT_DONE;
                        n_pos    = r_p;
                        n_cnt    = cnt_dec;
                        if (p_inc < r_cnt) begin
                            // Move the tail down over the removed slot
                            ram_raddr = IDX_W'(p_inc);
                            n_idx     = r_p;
                            n_state   = ST_SHIFT_DN;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_status = STAT_NOT_FOUND;
                        n_pos    = '0;
                        n_state  = ST_DONE;
                    end
                end
            end

            ST_SHIFT_UP: begin
                // Copy slot idx-1 into slot idx
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_idx);
                ram_wdata = ram_rdata;
                ram_raddr = IDX_W'(idx_dec2);
                n_idx     = idx_dec;
                if (idx_dec == r_p) begin
                    n_state = ST_PUT;
                end
            end

            ST_SHIFT_DN: begin
                // Copy slot idx+1 into slot idx
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_idx);
                ram_wdata = ram_rdata;
                ram_raddr = IDX_W'(idx_inc2);
                n_idx     = idx_inc;
                if (idx_inc == r_cnt) begin
                    n_state = ST_DONE;
                end
            end

            ST_PUT: begin
                // Write the new pair into its ordered slot
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_p);
                ram_wdata = {r_key_s, r_key_e};
                n_state   = ST_DONE;
            end

            ST_DONE: begin
                // Load the result once the output register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = r_pos;
                    n_out_cnt    = r_cnt;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive the ports
    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_position    = POS_W'(r_out_pos);
    assign o_entry_count = COUNT_W'(r_out_cnt);
    assign o_is_empty    = (r_out_cnt == '0);

endmodule

`default_nettype wire

### tb/sv/tb_sorted_interval_set_unit.sv
`timescale 1ns / 1ps

module tb_sorted_interval_set_unit;
    import sis_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int KEY_BITS       = 16;
    localparam logic [TIME_W-1:0] KEY_MASK = TIME_W'((64'd1 << KEY_BITS) - 1);
    // Worst case per operation is a full scan plus a full shift
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        t_status              status;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
    } t_set_result;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  i_cmd        = CMD_INSERT;
    logic [TIME_W-1:0]     i_start_time = '0;
    logic [TIME_W-1:0]     i_end_time   = '0;
    logic                  i_stall      = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [POS_W-1:0]      o_position;
    logic [COUNT_W-1:0]    o_entry_count;
    logic                  o_is_empty;

    // Predicted contents of the set, in order
    logic [TIME_W-1:0]     held_start [CAPACITY];
    logic [TIME_W-1:0]     held_end   [CAPACITY];
    int                    held_count = 0;
    t_set_result           awaited_results [$];

    bit                    idle_on = 1'b1;
    int                    stall_left = 0;
    int                    quiet_cycles = 0;
    int                    fail_count = 0;
    int                    ops_sent = 0;
    int                    results_checked = 0;
    int                    peak_count = 0;
    int                    status_tally [4] = '{0, 0, 0, 0};

    sorted_interval_set_unit #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_start_time  (i_start_time),
        .i_end_time    (i_end_time),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always #1 i_clk = ~i_clk;

    // Apply one operation to the predicted set and return its outcome
    function automatic t_set_result predict_set_update(input logic cmd,
            input logic [TIME_W-1:0] start_t, input logic [TIME_W-1:0] end_t);
        t_set_result           res;
        logic [2*TIME_W-1:0]   key;
        int                    pos;
        int                    i;
        bit                    hit;
        key = {start_t & KEY_MASK, end_t & KEY_MASK};
        // a pair orders as one word with start in the upper half
        pos = 0;
        while (pos < held_count && {held_start[pos], held_end[pos]} < key) pos++;
        hit = (pos < held_count) && ({held_start[pos], held_end[pos]} == key);
        res.status   = STAT_DONE;
        res.position = '0;
        if (cmd == CMD_INSERT) begin
            if (hit) begin
                res.status   = STAT_DUP;
                res.position = POS_W'(pos);
            end else if (held_count >= CAPACITY) begin
                res.status = STAT_FULL;
            end else begin
                // open a hole at the insert point
                for (i = held_count; i > pos; i--) begin
                    held_start[i] = held_start[i-1];
                    held_end[i]   = held_end[i-1];
                end
                held_start[pos] = key[2*TIME_W-1:TIME_W];
                held_end[pos]   = key[TIME_W-1:0];
                held_count++;
                res.position = POS_W'(pos);
            end
        end else if (hit) begin
            // close the gap left by the removed pair
            for (i = pos; i < held_count - 1; i++) begin
                held_start[i] = held_start[i+1];
                held_end[i]   = held_end[i+1];
            end
            held_count--;
            res.position = POS_W'(pos);
        end else begin
            res.status = STAT_NOT_FOUND;
        end
        res.entry_count = COUNT_W'(held_count);
        res.is_empty    = (held_count == 0);
        status_tally[res.status]++;
        if (held_count > peak_count) peak_count = held_count;
        return res;
    endfunction

    // Random pair, biased toward ties on start and toward extreme values
    function automatic logic [2*TIME_W-1:0] random_pair();
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        s = TIME_W'($urandom);
        e = TIME_W'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                s = TIME_W'($urandom_range(0, 7));
                e = TIME_W'($urandom_range(0, 7));
            end
            2: e = $urandom_range(0, 1) ? '1 : '0;
            default: s = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return {s, e};
    endfunction

    // Present one operation and hold it until the transfer
    task automatic send_op(input logic cmd, input logic [TIME_W-1:0] start_t,
            input logic [TIME_W-1:0] end_t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                while (awaited_results.size() != 0) @(posedge i_clk);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_start_time <= start_t;
        i_end_time   <= end_t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        awaited_results.push_back(predict_set_update(cmd, start_t, end_t));
        ops_sent++;
    endtask

    // One random operation; removes mostly target stored pairs
    task automatic random_op(input int insert_pct);
        logic              cmd;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        int                idx;
        int                pick;
        int                hit_pct;
        cmd     = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        pick    = $urandom_range(0, 99);
        hit_pct = (cmd == CMD_REMOVE) ? 75 : 15;
        idx     = (held_count != 0) ? $urandom_range(0, held_count - 1) : 0;
        if (held_count != 0 && pick < hit_pct) begin
            s = held_start[idx];
            e = held_end[idx];
        end else if (held_count != 0 && pick < hit_pct + 10) begin
            // near miss: same start, neighboring end
            s = held_start[idx];
            e = held_end[idx] + 1'b1;
        end else begin
            {s, e} = random_pair();
        end
        send_op(cmd, s, e);
    endtask

    task automatic test_empty_set();
        send_op(CMD_REMOVE, 16'h0000, 16'h0000);
        send_op(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_ordered_insert();
        send_op(CMD_INSERT, 16'h8000, 16'h8000);
        send_op(CMD_INSERT, 16'h0000, 16'h0000);
        send_op(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        send_op(CMD_INSERT, 16'h0000, 16'hFFFF);
        send_op(CMD_INSERT, 16'hFFFF, 16'h0000);
        send_op(CMD_INSERT, 16'h5555, 16'hAAAA);
        send_op(CMD_INSERT, 16'hAAAA, 16'h5555);
    endtask

    task automatic test_duplicates();
        send_op(CMD_INSERT, 16'h0000, 16'h0000);
        send_op(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        send_op(CMD_INSERT, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_remove_cases();
        send_op(CMD_REMOVE, 16'h0000, 16'h0001);
        send_op(CMD_REMOVE, 16'h8000, 16'h7FFF);
        send_op(CMD_REMOVE, 16'h5555, 16'hAAAA);
        send_op(CMD_REMOVE, 16'h0000, 16'h0000);
        send_op(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
        send_op(CMD_REMOVE, 16'h0000, 16'hFFFF);
        send_op(CMD_REMOVE, 16'hFFFF, 16'h0000);
        send_op(CMD_REMOVE, 16'hAAAA, 16'h5555);
        send_op(CMD_REMOVE, 16'h8000, 16'h8000);
        send_op(CMD_REMOVE, 16'h8000, 16'h8000);
    endtask

    // Fill the table, then hit it with full, duplicate and tail cases
    task automatic test_full_table();
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        while (held_count < CAPACITY) begin
            {s, e} = random_pair();
            send_op(CMD_INSERT, s, e);
        end
        {s, e} = random_pair();
        send_op(CMD_INSERT, s, e);
        send_op(CMD_INSERT, held_start[CAPACITY/2], held_end[CAPACITY/2]);
        s = held_start[CAPACITY-1];
        e = held_end[CAPACITY-1];
        send_op(CMD_REMOVE, s, e);
        send_op(CMD_INSERT, s, e);
        send_op(CMD_INSERT, held_start[CAPACITY-1], held_end[CAPACITY-1]);
    endtask

    // Swing the occupancy between full and empty
    task automatic test_fill_drain_rounds(input int rounds);
        int r;
        int guard;
        for (r = 0; r < rounds; r++) begin
            guard = 0;
            while (held_count < CAPACITY && guard < 400) begin
                random_op(80);
                guard++;
            end
            repeat (30) random_op(60);
            guard = 0;
            while (held_count > 0 && guard < 400) begin
                random_op(20);
                guard++;
            end
            repeat (10) random_op(30);
        end
    endtask

    task automatic test_mixed_traffic(input int n_ops);
        repeat (n_ops) random_op($urandom_range(35, 65));
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_fill_drain_rounds(1);
        test_mixed_traffic(150);
    endtask

    // Hold off results in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 2);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d position %0d count %0d empty %0d",
                         $time, o_status, o_position, o_entry_count, o_is_empty);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_position !== want.position) begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, o_position);
                    fail_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, o_entry_count);
                    fail_count++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0d actual %0d",
                             $time, want.is_empty, o_is_empty);
                    fail_count++;
                end
            end
        end
    end

    // End the run if no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_set();
        test_ordered_insert();
        test_duplicates();
        test_remove_cases();
        test_full_table();
        test_fill_drain_rounds(3);
        test_mixed_traffic(600);
        test_back_to_back();

        // Drop valid and drain outstanding results
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results for %0d operations; occupancy reached %0d of %0d.",
                 results_checked, ops_sent, peak_count, CAPACITY);
        $display("Outcomes: %0d done, %0d duplicate, %0d not found, %0d full; %0d mismatches.",
                 status_tally[STAT_DONE], status_tally[STAT_DUP],
                 status_tally[STAT_NOT_FOUND], status_tally[STAT_FULL], fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
